// File: design/led_overtemp_blink_controller_top_macros.svh
// Assertion macros for the LED overtemperature blink controller.
// No dependencies; included by the modules that carry assertions.
`ifndef LED_OVERTEMP_BLINK_CONTROLLER_TOP_MACROS_SVH
`define LED_OVERTEMP_BLINK_CONTROLLER_TOP_MACROS_SVH

// Same-cycle implication.
`define LOBC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define LOBC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/lobc_pkg.sv
// Package for the LED overtemperature blink controller: codes, reset values,
// item, result and register types. No dependencies.
`timescale 1ns / 1ps

package lobc_pkg;

   localparam int TempWidth  = 8;
   localparam int DutyWidth  = 8;
   localparam int TickWidth  = 12;
   localparam int FuncWidth  = 3;
   localparam int CodeWidth  = 2;
   localparam int IndexWidth = 3;
   localparam int CsrWidth   = 12;

   localparam logic [TickWidth-1:0] TICK_MAX = '1;

   // item functions
   localparam logic [FuncWidth-1:0] FUNC_TICK      = 3'd0;
   localparam logic [FuncWidth-1:0] FUNC_SET_RED   = 3'd1;
   localparam logic [FuncWidth-1:0] FUNC_SET_GREEN = 3'd2;
   localparam logic [FuncWidth-1:0] FUNC_SET_BLUE  = 3'd3;
   localparam logic [FuncWidth-1:0] FUNC_QUERY     = 3'd4;

   // register indexes
   localparam logic [IndexWidth-1:0] CSR_HIGH_THRESHOLD = 3'd0;
   localparam logic [IndexWidth-1:0] CSR_LOW_THRESHOLD  = 3'd1;
   localparam logic [IndexWidth-1:0] CSR_ON_TIME        = 3'd2;
   localparam logic [IndexWidth-1:0] CSR_OFF_TIME       = 3'd3;
   localparam logic [IndexWidth-1:0] CSR_WARN_RED       = 3'd4;
   localparam logic [IndexWidth-1:0] CSR_WARN_GREEN     = 3'd5;
   localparam logic [IndexWidth-1:0] CSR_WARN_BLUE      = 3'd6;

   // register reset values
   localparam logic [TempWidth-1:0] RESET_HIGH_THRESHOLD = 8'd100;
   localparam logic [TempWidth-1:0] RESET_LOW_THRESHOLD  = 8'd80;
   localparam logic [TickWidth-1:0] RESET_ON_TIME        = 12'd500;
   localparam logic [TickWidth-1:0] RESET_OFF_TIME       = 12'd2000;
   localparam logic [DutyWidth-1:0] RESET_WARN_RED       = 8'h30;
   localparam logic [DutyWidth-1:0] RESET_WARN_GREEN     = 8'h10;
   localparam logic [DutyWidth-1:0] RESET_WARN_BLUE      = 8'h10;

   // reported alarm codes
   localparam logic [CodeWidth-1:0] ALARM_CODE_NORMAL = 2'd0;
   localparam logic [CodeWidth-1:0] ALARM_CODE_LIT    = 2'd1;
   localparam logic [CodeWidth-1:0] ALARM_CODE_DARK   = 2'd2;

   typedef enum logic [2:0] {
      ALARM_NORMAL = 3'b001,
      ALARM_LIT    = 3'b010,
      ALARM_DARK   = 3'b100
   } alarm_type;

   typedef struct packed {
      logic [TempWidth-1:0] high_threshold;
      logic [TempWidth-1:0] low_threshold;
      logic [TickWidth-1:0] on_time;
      logic [TickWidth-1:0] off_time;
      logic [DutyWidth-1:0] warn_red;
      logic [DutyWidth-1:0] warn_green;
      logic [DutyWidth-1:0] warn_blue;
   } cfg_type;

   typedef struct packed {
      logic [FuncWidth-1:0] func;
      logic [DutyWidth-1:0] value;
      logic [TempWidth-1:0] led_temp;
      logic [TempWidth-1:0] cpu_temp;
   } req_type;

   typedef struct packed {
      logic [DutyWidth-1:0] drive_red;
      logic [DutyWidth-1:0] drive_green;
      logic [DutyWidth-1:0] drive_blue;
      logic [DutyWidth-1:0] stored_red;
      logic [DutyWidth-1:0] stored_green;
      logic [DutyWidth-1:0] stored_blue;
      logic [TempWidth-1:0] report_cpu_temp;
      logic [TempWidth-1:0] report_led_temp;
      logic [CodeWidth-1:0] alarm_state;
      logic                 is_report;
   } rsp_type;

   function automatic logic [CodeWidth-1:0] alarm_code(alarm_type mode);
      logic [CodeWidth-1:0] code;
      case (mode)
         ALARM_LIT:  code = ALARM_CODE_LIT;
         ALARM_DARK: code = ALARM_CODE_DARK;
         default:    code = ALARM_CODE_NORMAL;
      endcase
      return code;
   endfunction

endpackage

// File: design/lobc_core.sv
// Colour store, drive levels, blink timer and alarm state machine.
// Depends on lobc_pkg and led_overtemp_blink_controller_top_macros.svh.
`timescale 1ns / 1ps
`include "led_overtemp_blink_controller_top_macros.svh"

module lobc_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              step_valid,
   input  lobc_pkg::req_type step_item,
   input  lobc_pkg::cfg_type cfg,
   output lobc_pkg::rsp_type step_result
);

   logic [lobc_pkg::DutyWidth-1:0] color_ff [3];
   logic [lobc_pkg::DutyWidth-1:0] color_in [3];
   logic [lobc_pkg::DutyWidth-1:0] drive_ff [3];
   logic [lobc_pkg::DutyWidth-1:0] drive_in [3];
   logic [lobc_pkg::TickWidth-1:0] ticks_ff;
   logic [lobc_pkg::TickWidth-1:0] ticks_in;
   logic [lobc_pkg::TickWidth-1:0] ticks_cmd;
   lobc_pkg::alarm_type            mode_ff;
   lobc_pkg::alarm_type            mode_in;
   logic                           is_query;
   logic                           is_set;

   always_comb begin
      color_in  = color_ff;
      drive_in  = drive_ff;
      ticks_cmd = ticks_ff;
      mode_in   = mode_ff;
      is_query  = 1'b0;
      is_set    = 1'b0;

      // command part
      case (step_item.func)
         lobc_pkg::FUNC_TICK: begin
            if (ticks_ff != lobc_pkg::TICK_MAX) begin
               ticks_cmd = ticks_ff + 12'd1;
            end
         end
         lobc_pkg::FUNC_SET_RED: begin
            color_in[0] = step_item.value;
            is_set      = 1'b1;
         end
         lobc_pkg::FUNC_SET_GREEN: begin
            color_in[1] = step_item.value;
            is_set      = 1'b1;
         end
         lobc_pkg::FUNC_SET_BLUE: begin
            color_in[2] = step_item.value;
            is_set      = 1'b1;
         end
         lobc_pkg::FUNC_QUERY: begin
            is_query = 1'b1;
         end
         default: begin
         end
      endcase
      if (is_set) begin
         drive_in = color_in;
      end
      ticks_in = ticks_cmd;

      // temperature check
      case (mode_ff)
         lobc_pkg::ALARM_NORMAL: begin
            if (step_item.led_temp > cfg.high_threshold) begin
               drive_in = '{cfg.warn_red, cfg.warn_green, cfg.warn_blue};
               ticks_in = '0;
               mode_in  = lobc_pkg::ALARM_LIT;
            end
         end
         lobc_pkg::ALARM_LIT: begin
            if (step_item.led_temp < cfg.low_threshold) begin
               drive_in = color_in;
               mode_in  = lobc_pkg::ALARM_NORMAL;
            end else if (ticks_cmd > cfg.on_time) begin
               drive_in = '{'0, '0, '0};
               ticks_in = '0;
               mode_in  = lobc_pkg::ALARM_DARK;
            end
         end
         lobc_pkg::ALARM_DARK: begin
            if (step_item.led_temp < cfg.low_threshold) begin
               drive_in = color_in;
               mode_in  = lobc_pkg::ALARM_NORMAL;
            end else if (ticks_cmd > cfg.off_time) begin
               drive_in = '{cfg.warn_red, cfg.warn_green, cfg.warn_blue};
               ticks_in = '0;
               mode_in  = lobc_pkg::ALARM_LIT;
            end
         end
         default: begin
            mode_in = lobc_pkg::ALARM_NORMAL;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         color_ff <= '{'0, '0, '0};
         drive_ff <= '{'0, '0, '0};
         ticks_ff <= '0;
         mode_ff  <= lobc_pkg::ALARM_NORMAL;
      end else if (step_valid) begin
         color_ff <= color_in;
         drive_ff <= drive_in;
         ticks_ff <= ticks_in;
         mode_ff  <= mode_in;
      end
   end

   always_comb begin
      step_result.drive_red       = drive_in[0];
      step_result.drive_green     = drive_in[1];
      step_result.drive_blue      = drive_in[2];
      step_result.stored_red      = color_in[0];
      step_result.stored_green    = color_in[1];
      step_result.stored_blue     = color_in[2];
      step_result.report_cpu_temp = is_query ? step_item.cpu_temp : '0;
      step_result.report_led_temp = is_query ? step_item.led_temp : '0;
      step_result.alarm_state     = lobc_pkg::alarm_code(mode_in);
      step_result.is_report       = is_query;
   end

   `LOBC_ASSERT_NEXT(a_hot_enters_alarm, clock, reset,
      step_valid && step_item.led_temp > cfg.high_threshold
         && step_item.led_temp >= cfg.low_threshold,
      mode_ff != lobc_pkg::ALARM_NORMAL, "hot item left alarm normal")
   `LOBC_ASSERT_NEXT(a_cool_leaves_alarm, clock, reset,
      step_valid && step_item.led_temp < cfg.low_threshold
         && mode_ff != lobc_pkg::ALARM_NORMAL,
      mode_ff == lobc_pkg::ALARM_NORMAL, "cool item kept alarm")
   `LOBC_ASSERT_NEXT(a_ticks_hold_idle, clock, reset,
      !step_valid, $stable(ticks_ff), "blink timer moved without item")

endmodule

// File: design/led_overtemp_blink_controller_top.sv
// RGB LED drive with overtemperature blink: one result per item. An item is
// taken every clock while the result side does not stall; it is held in the
// input register, its update of colours, blink timer and alarm state is done
// in one pass, and the result register captures it, so throughput is one item
// per clock without stalls, set by the one-pass state update in lobc_core.
// Stalls on the result side back up through the input register.
// Depends on lobc_pkg and lobc_core.
`timescale 1ns / 1ps

module led_overtemp_blink_controller_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [7:0] value, [15:8] led_temp, [23:16] cpu_temp
   input  logic [23:0] req_tdata,
   // [2:0] func
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] drive_red, [15:8] drive_green, [23:16] drive_blue,
   // [31:24] stored_red, [39:32] stored_green, [47:40] stored_blue,
   // [55:48] report_cpu_temp, [63:56] report_led_temp,
   // [65:64] alarm_state, [71:66] zero
   output logic [71:0] rsp_tdata,
   // [0] is_report
   output logic [0:0]  rsp_tuser,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [lobc_pkg::IndexWidth-1:0] csr_index,
   input  logic [lobc_pkg::CsrWidth-1:0]   csr_data
);

   lobc_pkg::cfg_type cfg_ff;
   lobc_pkg::cfg_type cfg_in;
   logic              in_valid_ff;
   logic              in_valid_in;
   lobc_pkg::req_type in_item_ff;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   lobc_pkg::rsp_type rsp_item_ff;
   lobc_pkg::rsp_type step_result;
   lobc_pkg::req_type req_item;
   logic              req_transfer;
   logic              advance;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            lobc_pkg::CSR_HIGH_THRESHOLD: cfg_in.high_threshold = csr_data[7:0];
            lobc_pkg::CSR_LOW_THRESHOLD:  cfg_in.low_threshold  = csr_data[7:0];
            lobc_pkg::CSR_ON_TIME:        cfg_in.on_time        = csr_data;
            lobc_pkg::CSR_OFF_TIME:       cfg_in.off_time       = csr_data;
            lobc_pkg::CSR_WARN_RED:       cfg_in.warn_red       = csr_data[7:0];
            lobc_pkg::CSR_WARN_GREEN:     cfg_in.warn_green     = csr_data[7:0];
            lobc_pkg::CSR_WARN_BLUE:      cfg_in.warn_blue      = csr_data[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.high_threshold <= lobc_pkg::RESET_HIGH_THRESHOLD;
         cfg_ff.low_threshold  <= lobc_pkg::RESET_LOW_THRESHOLD;
         cfg_ff.on_time        <= lobc_pkg::RESET_ON_TIME;
         cfg_ff.off_time       <= lobc_pkg::RESET_OFF_TIME;
         cfg_ff.warn_red       <= lobc_pkg::RESET_WARN_RED;
         cfg_ff.warn_green     <= lobc_pkg::RESET_WARN_GREEN;
         cfg_ff.warn_blue      <= lobc_pkg::RESET_WARN_BLUE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // advance the held item into the result register when it is free
   assign advance      = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready   = !in_valid_ff || advance;
   assign req_transfer = req_tvalid && req_tready;
   assign in_valid_in  = req_transfer || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);

   always_comb begin
      req_item.func     = req_tuser;
      req_item.value    = req_tdata[7:0];
      req_item.led_temp = req_tdata[15:8];
      req_item.cpu_temp = req_tdata[23:16];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_transfer) begin
         in_item_ff <= req_item;
      end
      if (advance) begin
         rsp_item_ff <= step_result;
      end
   end

   lobc_core u_core (
      .clock       (clock),
      .reset       (reset),
      .step_valid  (advance),
      .step_item   (in_item_ff),
      .cfg         (cfg_ff),
      .step_result (step_result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0,
                        rsp_item_ff.alarm_state,
                        rsp_item_ff.report_led_temp,
                        rsp_item_ff.report_cpu_temp,
                        rsp_item_ff.stored_blue,
                        rsp_item_ff.stored_green,
                        rsp_item_ff.stored_red,
                        rsp_item_ff.drive_blue,
                        rsp_item_ff.drive_green,
                        rsp_item_ff.drive_red};
   assign rsp_tuser  = rsp_item_ff.is_report;

endmodule
